@@ design/spp_pkg.sv @@
// spp_pkg: shared types, constants and decode functions of the sonar packet parser.
// Used by spp_front, spp_cmd_fifo, spp_back and sonar_packet_parser; no dependencies.
package spp_pkg;

  localparam int HEADER_BYTES_DEF     = 20;
  localparam int MAX_SAMPLE_BYTES_DEF = 16384;
  localparam int CMD_FIFO_DEPTH_DEF   = 4;

  localparam int BC_W     = 15;
  localparam int N_HDR    = 12;
  localparam int TS_FIRST = 12;
  localparam int TS_LAST  = 19;
  localparam logic [BC_W-1:0] COUNT_MAX = 15'h7FFF;

  localparam logic [7:0] MAGIC_0        = 8'h49;
  localparam logic [7:0] MAGIC_1        = 8'h53;
  localparam logic [7:0] MAGIC_2        = 8'h58;
  localparam logic [7:0] MASK_POS       = 8'h3E;
  localparam logic [7:0] MASK_DBT       = 8'h7E;
  localparam logic [7:0] TERM_RESET     = 8'hFC;
  localparam logic [0:0] REG_TERMINATOR = 1'b0;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_TOO_SHORT     = 3'd1,
    ST_BAD_MAGIC     = 3'd2,
    ST_BAD_TERM      = 3'd3,
    ST_NO_SAMPLES    = 3'd4,
    ST_SIZE_MISMATCH = 3'd5
  } status_t;

  typedef logic [N_HDR-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  frame_kind;
    logic [3:0]  packet_count;
    logic [3:0]  packet_number;
    logic [12:0] head_position;
    logic        scan_direction;
    logic [11:0] range_cm;
    logic [12:0] profile_samples;
    logic [63:0] timestamp;
  } hdr_t;

  typedef struct packed {
    logic        is_final;
    logic [7:0]  sample_value;
    logic [13:0] sample_index;
    logic [2:0]  status;
    logic [7:0]  frame_kind;
    logic [3:0]  packet_count;
    logic [3:0]  packet_number;
    logic [12:0] head_position;
    logic        scan_direction;
    logic [11:0] range_cm;
    logic [12:0] profile_samples;
    logic [63:0] timestamp;
  } out_item_t;

  // One classified byte: up to one sample and one status item.
  typedef struct packed {
    logic        has_sample;
    logic        has_final;
    logic [7:0]  sample_value;
    logic [13:0] sample_index;
    status_t     status;
    hdr_t        hdr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = MAGIC_0;
      2'd1:    m = MAGIC_1;
      default: m = MAGIC_2;
    endcase
    return m;
  endfunction

  // Join two 7-bit-coded bytes into one 14-bit number.
  function automatic logic [13:0] pair7(input logic [7:0] lo_b, input logic [7:0] hi_b,
                                        input logic [7:0] mask);
    logic [7:0] m;
    m = hi_b & mask;
    return {m[6:1], hi_b[0], lo_b[6:0]};
  endfunction

  function automatic logic [11:0] range_to_cm(input logic [7:0] code);
    logic [11:0] cm;
    case (code)
      8'd4:    cm = 12'd25;
      8'd6:    cm = 12'd50;
      8'd8:    cm = 12'd75;
      default: cm = ({4'b0, code} << 3) + ({4'b0, code} << 1);
    endcase
    return cm;
  endfunction

  function automatic hdr_t decode_hdr(input hdr_bytes_t hb, input logic [63:0] ts);
    hdr_t h;
    logic [13:0] pos;
    logic [13:0] prof;
    pos               = pair7(hb[5], hb[6], MASK_POS);
    prof              = pair7(hb[8], hb[9], MASK_POS);
    h.frame_kind      = hb[3];
    h.packet_count    = hb[4][7:4];
    h.packet_number   = hb[4][3:0];
    h.head_position   = pos[12:0];
    h.scan_direction  = hb[6][6];
    h.range_cm        = range_to_cm(hb[7]);
    h.profile_samples = prof[12:0];
    h.timestamp       = ts;
    return h;
  endfunction

endpackage

@@ design/sonar_packet_parser.sv @@
// sonar_packet_parser: top level of the streaming sonar packet parser.
// Instantiates spp_front, spp_cmd_fifo and spp_back; uses spp_pkg.
//
//   channel   ports                                         beat moves when
//   -------   -------------------------------------------   --------------------------
//   input     push, full, in_data (spp_pkg::in_item_t)      push && !full
//   result    empty, pop, out_data (spp_pkg::out_item_t)    pop && !empty
//   config    psel, penable, pwrite, paddr, pwdata,         psel && penable && pwrite
//             prdata, pready (APB, one register)
//
// One packet byte is accepted per cycle while the command queue is not full. A byte
// gives zero, one or two result beats; the result side drains one beat per cycle
// while pop is held, so a byte that carries both a sample and the status takes two
// output beats, absorbed by the command queue. Commands pass through the queue and the
// output stage register. Reset is synchronous on rst_n low; no clearing pass.
// full rises only when the command queue fills, which happens only under pop stalls.
module sonar_packet_parser #(
  parameter int HEADER_BYTES     = spp_pkg::HEADER_BYTES_DEF,
  parameter int MAX_SAMPLE_BYTES = spp_pkg::MAX_SAMPLE_BYTES_DEF,
  parameter int CMD_FIFO_DEPTH   = spp_pkg::CMD_FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               push,
  output logic               full,
  input  spp_pkg::in_item_t  in_data,
  // result channel
  output logic               empty,
  input  logic               pop,
  output spp_pkg::out_item_t out_data,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic                accept;
  logic                cmd_wr;
  logic                q_rd;
  spp_pkg::cmd_t       cmd;
  spp_pkg::cmd_t       q_data;
  spp_pkg::fifo_stat_t q_stat;
  logic [7:0]          term_r, term_nxt;
  logic                reg_sel;

  // Configuration: register index is the word address; only the terminator exists.
  assign reg_sel = (paddr[2] == spp_pkg::REG_TERMINATOR);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {24'd0, term_r} : 32'd0;

  always_comb begin
    term_nxt = term_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      term_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r <= spp_pkg::TERM_RESET;
    end else begin
      term_r <= term_nxt;
    end
  end

  // Front stalls only when the command queue is full.
  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  spp_front #(
    .HEADER_BYTES     (HEADER_BYTES),
    .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_data),
    .term_byte (term_r),
    .cmd_wr    (cmd_wr),
    .cmd       (cmd)
  );

  spp_cmd_fifo #(
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .stat    (q_stat)
  );

  spp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_data),
    .q_stat   (q_stat),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_data)
  );

endmodule

@@ design/spp_front.sv @@
// spp_front: accepts packet bytes, tracks header state and classifies each byte
// into a command for the back end. Depends on spp_pkg.
module spp_front #(
  parameter int HEADER_BYTES     = spp_pkg::HEADER_BYTES_DEF,
  parameter int MAX_SAMPLE_BYTES = spp_pkg::MAX_SAMPLE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  spp_pkg::in_item_t in_item,
  input  logic [7:0]        term_byte,
  output logic              cmd_wr,
  output spp_pkg::cmd_t     cmd
);

  localparam logic [spp_pkg::BC_W-1:0] HDR_N = spp_pkg::BC_W'(HEADER_BYTES);
  localparam logic [spp_pkg::BC_W-1:0] MAX_N = spp_pkg::BC_W'(MAX_SAMPLE_BYTES);

  logic [spp_pkg::BC_W-1:0] byte_count_r, byte_count_nxt;
  logic                     magic_ok_r, magic_ok_nxt;
  spp_pkg::hdr_bytes_t      hb_r, hb_nxt, hb_upd;
  logic [63:0]              ts_r, ts_nxt, ts_upd;
  logic [7:0]               held_byte_r, held_byte_nxt;
  logic                     held_valid_r, held_valid_nxt;

  logic [spp_pkg::BC_W-1:0] p;
  logic [spp_pkg::BC_W-1:0] idx;
  logic [spp_pkg::BC_W-1:0] cnt;
  logic [13:0]              dbt;
  logic                     magic_upd;
  logic                     in_payload;
  logic                     b_eop;
  logic [7:0]               b;
  spp_pkg::status_t         st;

  always_comb begin
    p     = byte_count_r;
    b     = in_item.data_byte;
    b_eop = in_item.end_of_packet;

    magic_upd = magic_ok_r;
    if (p < spp_pkg::BC_W'(3) && b != spp_pkg::magic_byte(p[1:0])) begin
      magic_upd = 1'b0;
    end

    for (int i = 0; i < spp_pkg::N_HDR; i++) begin
      hb_upd[i] = (p == spp_pkg::BC_W'(i)) ? b : hb_r[i];
    end

    ts_upd = ts_r;
    if (p >= spp_pkg::BC_W'(spp_pkg::TS_FIRST) && p <= spp_pkg::BC_W'(spp_pkg::TS_LAST)) begin
      ts_upd = {ts_r[55:0], b};
    end

    in_payload = (p >= HDR_N);
    idx        = p - HDR_N - spp_pkg::BC_W'(1);
    cnt        = p - HDR_N;
    dbt        = spp_pkg::pair7(hb_upd[10], hb_upd[11], spp_pkg::MASK_DBT);

    if (p < HDR_N) begin
      st = spp_pkg::ST_TOO_SHORT;
    end else if (!magic_upd) begin
      st = spp_pkg::ST_BAD_MAGIC;
    end else if (b != term_byte) begin
      st = spp_pkg::ST_BAD_TERM;
    end else if (p == HDR_N) begin
      st = spp_pkg::ST_NO_SAMPLES;
    end else if (hb_upd[4][7:4] <= 4'd1 && dbt != 14'd0 && cnt != {1'b0, dbt}) begin
      st = spp_pkg::ST_SIZE_MISMATCH;
    end else begin
      st = spp_pkg::ST_OK;
    end

    cmd.has_sample   = in_payload && held_valid_r && magic_upd && (idx < MAX_N);
    cmd.has_final    = b_eop;
    cmd.sample_value = held_byte_r;
    cmd.sample_index = idx[13:0];
    cmd.status       = b_eop ? st : spp_pkg::ST_OK;
    cmd.hdr          = spp_pkg::decode_hdr(hb_upd, ts_upd);
    cmd_wr           = accept && (cmd.has_sample || cmd.has_final);

    // Next state: advance on accepted bytes, drop everything at packet end.
    byte_count_nxt = byte_count_r;
    magic_ok_nxt   = magic_ok_r;
    hb_nxt         = hb_r;
    ts_nxt         = ts_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    if (accept) begin
      if (b_eop) begin
        byte_count_nxt = '0;
        magic_ok_nxt   = 1'b1;
        hb_nxt         = '0;
        ts_nxt         = '0;
        held_byte_nxt  = '0;
        held_valid_nxt = 1'b0;
      end else begin
        byte_count_nxt = (p != spp_pkg::COUNT_MAX) ? p + spp_pkg::BC_W'(1) : p;
        magic_ok_nxt   = magic_upd;
        hb_nxt         = hb_upd;
        ts_nxt         = ts_upd;
        if (in_payload) begin
          held_byte_nxt  = b;
          held_valid_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      magic_ok_r   <= 1'b1;
      hb_r         <= '0;
      ts_r         <= '0;
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      magic_ok_r   <= magic_ok_nxt;
      hb_r         <= hb_nxt;
      ts_r         <= ts_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_held_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> byte_count_r > HDR_N)
    else $error("held byte valid before header end");

  a_clear_on_eop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.end_of_packet |=> byte_count_r == '0 && !held_valid_r)
    else $error("packet state not cleared after end of packet");
`endif

endmodule

@@ design/spp_cmd_fifo.sv @@
// spp_cmd_fifo: short register queue of classified commands between front and back.
// Depends on spp_pkg.
module spp_cmd_fifo #(
  parameter int DEPTH = spp_pkg::CMD_FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  spp_pkg::cmd_t        wr_data,
  input  logic                 rd_en,
  output spp_pkg::cmd_t        rd_data,
  output spp_pkg::fifo_stat_t  stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  spp_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  always_comb begin
    stat.full  = (count_r == (AW + 1)'(DEPTH));
    stat.empty = (count_r == '0);
    rd_data    = mem_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + (AW + 1)'(1);
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.full |-> !wr_en) and (stat.empty |-> !rd_en))
    else $error("command queue written full or read empty");
`endif

endmodule

@@ design/spp_back.sv @@
// spp_back: output stage; expands each command into its sample and status beats.
// Depends on spp_pkg.
module spp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  spp_pkg::cmd_t       q_data,
  input  spp_pkg::fifo_stat_t q_stat,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output spp_pkg::out_item_t  out_item
);

  spp_pkg::cmd_t cur_r, cur_nxt;
  logic          cur_valid_r, cur_valid_nxt;
  logic          taken;

  always_comb begin
    taken = pop && cur_valid_r;
    empty = !cur_valid_r;

    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    q_rd          = 1'b0;
    if (taken && cur_r.has_sample && cur_r.has_final) begin
      // Sample beat gone; hold the status beat.
      cur_nxt.has_sample = 1'b0;
    end else if (!cur_valid_r || taken) begin
      q_rd          = !q_stat.empty;
      cur_valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        cur_nxt = q_data;
      end
    end

    out_item.is_final        = !cur_r.has_sample;
    out_item.sample_value    = cur_r.has_sample ? cur_r.sample_value : 8'd0;
    out_item.sample_index    = cur_r.has_sample ? cur_r.sample_index : 14'd0;
    out_item.status          = cur_r.has_sample ? 3'(spp_pkg::ST_OK) : 3'(cur_r.status);
    out_item.frame_kind      = cur_r.hdr.frame_kind;
    out_item.packet_count    = cur_r.hdr.packet_count;
    out_item.packet_number   = cur_r.hdr.packet_number;
    out_item.head_position   = cur_r.hdr.head_position;
    out_item.scan_direction  = cur_r.hdr.scan_direction;
    out_item.range_cm        = cur_r.hdr.range_cm;
    out_item.profile_samples = cur_r.hdr.profile_samples;
    out_item.timestamp       = cur_r.hdr.timestamp;
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cur_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.has_sample || cur_r.has_final))
    else $error("output stage holds a command with no beat");
`endif

endmodule
